[rtl/i2c_register_access_master_unit_assert.svh]
// Assertion macros shared by the I2C register access master RTL.
`ifndef I2C_REGISTER_ACCESS_MASTER_UNIT_ASSERT_SVH
`define I2C_REGISTER_ACCESS_MASTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define I2CRAM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define I2CRAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define I2CRAM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define I2CRAM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/i2cram_pkg.sv]
// Types and constants of the I2C register access master.
package i2cram_pkg;

	localparam int IN_W  = 24;
	localparam int OUT_W = 16;

	// Configuration register indexes.
	localparam logic [1:0] REG_DEV_ADDR = 2'd0;
	localparam logic [1:0] REG_DELAY    = 2'd1;
	localparam logic [1:0] REG_TIMEOUT  = 2'd2;

	localparam logic [2:0] STEP_ADDR = 3'd0;
	localparam logic [2:0] STEP_REG  = 3'd1;
	localparam logic [2:0] STEP_LAST = 3'd2;
	localparam logic [2:0] STEP_END  = 3'd3;

	typedef struct packed {
		logic       sda_in;
		logic [7:0] write_value;
		logic [7:0] reg_address;
		logic       command;
		logic       request;
	} item_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic       status;
		logic       done_res;
		logic       busy_res;
		logic       sda_drive;
		logic       sda_level;
		logic       scl_level;
	} result_t;

	typedef enum logic [21:0] {
		P_IDLE    = 22'h000001,
		P_ST1     = 22'h000002,
		P_ST2     = 22'h000004,
		P_ST3     = 22'h000008,
		P_WB_PRE  = 22'h000010,
		P_WB_LO   = 22'h000020,
		P_WB_HI   = 22'h000040,
		P_WB_ALO  = 22'h000080,
		P_WB_AHI  = 22'h000100,
		P_WB_POLL = 22'h000200,
		P_WB_ATL  = 22'h000400,
		P_RB_PRE  = 22'h000800,
		P_RB_LO   = 22'h001000,
		P_RB_HI   = 22'h002000,
		P_RB_SMP  = 22'h004000,
		P_RB_NLO  = 22'h008000,
		P_RB_NHI  = 22'h010000,
		P_RB_NLO2 = 22'h020000,
		P_RB_NEND = 22'h040000,
		P_SP1     = 22'h080000,
		P_SP2     = 22'h100000,
		P_SP3     = 22'h200000
	} phase_t;

endpackage

[rtl/i2cram_front.sv]
// Input side: unpacks tick words and queues them in a two-entry buffer.
`include "i2c_register_access_master_unit_assert.svh"
module i2cram_front import i2cram_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [IN_W-1:0] s_axis_tdata,
	output logic            item_valid,
	output item_t           item,
	input  logic            item_pop
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign s_axis_tready = (count_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign item_valid    = (count_q != 2'd0);
	assign item          = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (item_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, item_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`I2CRAM_ASSERT_SAME(a_count_range, clk, arst_n, 1'b1, count_q <= 2'd2)
	`I2CRAM_ASSERT_SAME(a_pop_nonempty, clk, arst_n, item_pop, count_q != 2'd0)
	`I2CRAM_ASSERT_NEXT(a_fill, clk, arst_n, push && !item_pop && count_q == 2'd1, !s_axis_tready)

endmodule

[rtl/i2cram_engine.sv]
// Bus engine: steps the I2C sequencer by one tick per queued word.
`include "i2c_register_access_master_unit_assert.svh"
module i2cram_engine import i2cram_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [6:0]             dev_addr,
	input  logic [COUNT_WIDTH-1:0] delay_ticks,
	input  logic [COUNT_WIDTH-1:0] ack_timeout,
	input  logic                   item_valid,
	input  item_t                  item,
	output logic                   item_pop,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_W-1:0]       m_axis_tdata
);

	phase_t                 ph_q;
	logic [3:0]             bc_q;
	logic [2:0]             bs_q;
	logic [COUNT_WIDTH-1:0] tk_q;
	logic [COUNT_WIDTH-1:0] aw_q;
	logic [7:0]             sh_q;
	logic [7:0]             rr_q;
	logic                   pc_q;
	logic [7:0]             pr_q;
	logic [7:0]             pd_q;
	logic                   ef_q;
	logic                   scl_q;
	logic                   sda_q;
	logic                   drv_q;
	result_t                out_q;
	logic                   out_valid_q;

	phase_t                 ph;
	logic [3:0]             bc;
	logic [2:0]             bs;
	logic [2:0]             nbs;
	logic [COUNT_WIDTH-1:0] tk;
	logic [COUNT_WIDTH-1:0] aw;
	logic [COUNT_WIDTH-1:0] seg;
	logic [7:0]             sh;
	logic [7:0]             rr;
	logic                   pc;
	logic [7:0]             pr;
	logic [7:0]             pd;
	logic                   ef;
	logic                   scl;
	logic                   sda;
	logic                   drv;
	result_t                res;

	function automatic logic [7:0] load_byte(input logic [2:0] step, input logic [6:0] dev,
			input logic cmd, input logic [7:0] rg, input logic [7:0] dat);
		logic [7:0] b;
		if (step == STEP_ADDR) begin
			b = {dev, 1'b0};
		end else if (step == STEP_REG) begin
			b = rg;
		end else begin
			b = cmd ? {dev, 1'b1} : dat;
		end
		return b;
	endfunction

	assign item_pop      = item_valid && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_W - $bits(result_t)){1'b0}}, out_q};

	always_comb begin
		ph  = ph_q;
		bc  = bc_q;
		bs  = bs_q;
		nbs = bs_q + 3'd1;
		tk  = tk_q;
		aw  = aw_q;
		sh  = sh_q;
		rr  = rr_q;
		pc  = pc_q;
		pr  = pr_q;
		pd  = pd_q;
		ef  = ef_q;
		scl = scl_q;
		sda = sda_q;
		drv = drv_q;
		seg = delay_ticks;
		res = '0;

		if (ph == P_IDLE && item.request) begin
			pc = item.command;
			pr = item.reg_address;
			pd = item.write_value;
			ef = 1'b0;
			bs = STEP_ADDR;
			bc = 4'd0;
			tk = '0;
			ph = P_ST1;
		end

		// Entry actions run on the first tick of every phase but the ACK poll.
		if (ph != P_IDLE) begin
			res.busy_res = 1'b1;
			if (ph != P_WB_POLL && tk == '0) begin
				case (ph)
					P_ST1:     begin scl = 1'b1; sda = 1'b1; drv = 1'b1; end
					P_ST2:     sda = 1'b0;
					P_ST3:     scl = 1'b0;
					P_WB_PRE:  drv = 1'b1;
					P_WB_LO:   begin scl = 1'b0; sda = sh[bc[2:0]]; end
					P_WB_HI:   scl = 1'b1;
					P_WB_ALO:  begin scl = 1'b0; drv = 1'b0; end
					P_WB_AHI:  scl = 1'b1;
					P_RB_PRE:  drv = 1'b0;
					P_RB_LO:   scl = 1'b0;
					P_RB_HI:   scl = 1'b1;
					P_RB_SMP:  if (item.sda_in) sh[bc[2:0]] = 1'b1;
					P_RB_NLO:  begin scl = 1'b0; drv = 1'b1; sda = 1'b1; end
					P_RB_NHI:  scl = 1'b1;
					P_RB_NLO2: scl = 1'b0;
					P_RB_NEND: sda = 1'b1;
					P_SP1:     sda = 1'b0;
					P_SP2:     scl = 1'b1;
					P_SP3:     sda = 1'b1;
					default:   ;
				endcase
			end
		end
		res.scl_level = scl;
		res.sda_level = sda;
		res.sda_drive = drv;

		// The ACK check and the read sample point sit half a step after SCL rises.
		if (ph == P_WB_AHI || ph == P_WB_ATL || ph == P_RB_HI || ph == P_RB_SMP) begin
			seg = delay_ticks >> 1;
		end
		if (seg == '0) begin
			seg = COUNT_WIDTH'(1);
		end

		if (ph == P_WB_POLL) begin
			if (!item.sda_in) begin
				if (aw >= ack_timeout) begin
					ef = 1'b1;
				end
				tk = '0;
				ph = P_WB_ATL;
			end else if (aw < ack_timeout) begin
				aw = aw + COUNT_WIDTH'(1);
			end else begin
				ef = 1'b1;
				tk = '0;
				ph = P_WB_ATL;
			end
		end else if (ph != P_IDLE) begin
			tk = tk + COUNT_WIDTH'(1);
			if (tk == '0 || tk >= seg) begin
				tk = '0;
				case (ph)
					P_ST1: ph = P_ST2;
					P_ST2: ph = P_ST3;
					P_ST3: begin
						sh = load_byte(bs, dev_addr, pc, pr, pd);
						bc = 4'd7;
						ph = P_WB_PRE;
					end
					P_WB_PRE: ph = P_WB_LO;
					P_WB_LO:  ph = P_WB_HI;
					P_WB_HI: begin
						if (bc != 4'd0) begin
							bc = bc - 4'd1;
							ph = P_WB_LO;
						end else begin
							ph = P_WB_ALO;
						end
					end
					P_WB_ALO: ph = P_WB_AHI;
					P_WB_AHI: begin
						aw = '0;
						ph = P_WB_POLL;
					end
					P_WB_ATL: begin
						scl = 1'b0;
						drv = 1'b1;
						if (ef) begin
							ph = P_SP1;
						end else if (!pc) begin
							if (nbs >= STEP_END) begin
								ph = P_SP1;
							end else begin
								bs = nbs;
								sh = load_byte(nbs, dev_addr, pc, pr, pd);
								bc = 4'd7;
								ph = P_WB_PRE;
							end
						end else if (nbs == STEP_REG) begin
							bs = nbs;
							sh = load_byte(nbs, dev_addr, pc, pr, pd);
							bc = 4'd7;
							ph = P_WB_PRE;
						end else if (nbs == STEP_LAST) begin
							// Register byte sent: repeated START, then address with read bit.
							bs = nbs;
							ph = P_ST1;
						end else begin
							sh = 8'h00;
							bc = 4'd7;
							ph = P_RB_PRE;
						end
					end
					P_RB_PRE: ph = P_RB_LO;
					P_RB_LO:  ph = P_RB_HI;
					P_RB_HI:  ph = P_RB_SMP;
					P_RB_SMP: begin
						if (bc != 4'd0) begin
							bc = bc - 4'd1;
							ph = P_RB_LO;
						end else begin
							ph = P_RB_NLO;
						end
					end
					P_RB_NLO:  ph = P_RB_NHI;
					P_RB_NHI:  ph = P_RB_NLO2;
					P_RB_NLO2: ph = P_RB_NEND;
					P_RB_NEND: begin
						rr = sh;
						ph = P_SP1;
					end
					P_SP1: ph = P_SP2;
					P_SP2: ph = P_SP3;
					P_SP3: begin
						ph = P_IDLE;
						res.done_res = 1'b1;
						res.status   = ef;
					end
					default: ph = P_IDLE;
				endcase
			end
		end
		res.read_value = rr;
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= P_IDLE;
			bc_q        <= 4'd0;
			bs_q        <= STEP_ADDR;
			tk_q        <= '0;
			aw_q        <= '0;
			sh_q        <= 8'h00;
			rr_q        <= 8'h00;
			pc_q        <= 1'b0;
			pr_q        <= 8'h00;
			pd_q        <= 8'h00;
			ef_q        <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			drv_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (item_pop) begin
				ph_q  <= ph;
				bc_q  <= bc;
				bs_q  <= bs;
				tk_q  <= tk;
				aw_q  <= aw;
				sh_q  <= sh;
				rr_q  <= rr;
				pc_q  <= pc;
				pr_q  <= pr;
				pd_q  <= pd;
				ef_q  <= ef;
				scl_q <= scl;
				sda_q <= sda;
				drv_q <= drv;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`I2CRAM_ASSERT_SAME(a_done_busy, clk, arst_n, out_valid_q && out_q.done_res, out_q.busy_res)
	`I2CRAM_ASSERT_SAME(a_status_done, clk, arst_n, out_valid_q && out_q.status, out_q.done_res)
	`I2CRAM_ASSERT_NEXT(a_done_idle, clk, arst_n, item_pop && res.done_res, ph_q == P_IDLE)

endmodule

[rtl/i2c_register_access_master_unit.sv]
// Top level of the I2C register access master: configuration registers and stream wiring.
//
// Each input word on the s_axis channel is one timing tick of the I2C engine. It carries
// the sampled SDA level and, when the engine is idle, an optional request to write or
// read one 8-bit register of the target. Every accepted word produces exactly one result
// word on the m_axis channel with the SCL/SDA levels, SDA drive enable, busy, done,
// status and the last byte read.
// A result passes from input acceptance to result valid through the two-entry input
// buffer and the engine's output register. Throughput is one word per cycle while the
// output side takes them; words stream back to back.
// When the receiver stalls, the result waits in the output register and the input buffer
// absorbs up to two more words before s_axis_tready drops.
// Configuration (device address, delay step, ACK timeout) is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while the engine is idle, which
// the block itself does not enforce. After reset the bus lines are released high, the
// engine is idle, the delay step is 6 ticks and the ACK timeout is 1000 ticks.
module i2c_register_access_master_unit import i2cram_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// request, command, reg_address[7:0], write_value[7:0], sda_in, zero pad
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// scl_level, sda_level, sda_drive, busy_res, done_res, status, read_value[7:0], pad
	output logic [OUT_W-1:0] m_axis_tdata,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data
);

	logic [6:0]             dev_addr_q;
	logic [COUNT_WIDTH-1:0] delay_q;
	logic [COUNT_WIDTH-1:0] timeout_q;
	logic                   item_valid;
	item_t                  item;
	logic                   item_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= 7'd0;
			delay_q    <= COUNT_WIDTH'(32'd6);
			timeout_q  <= COUNT_WIDTH'(32'd1000);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEV_ADDR: dev_addr_q <= cfg_data[6:0];
				REG_DELAY:    delay_q    <= COUNT_WIDTH'(32'(cfg_data));
				REG_TIMEOUT:  timeout_q  <= COUNT_WIDTH'(32'(cfg_data));
				default:      ;
			endcase
		end
	end

	i2cram_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.item_valid    (item_valid),
		.item          (item),
		.item_pop      (item_pop)
	);

	i2cram_engine #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.dev_addr      (dev_addr_q),
		.delay_ticks   (delay_q),
		.ack_timeout   (timeout_q),
		.item_valid    (item_valid),
		.item          (item),
		.item_pop      (item_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
